[hw/rtl/swept_box_collision_response_macros.svh]
// Assertion helpers used by the RTL.
`ifndef SWEPT_BOX_COLLISION_RESPONSE_MACROS_SVH
`define SWEPT_BOX_COLLISION_RESPONSE_MACROS_SVH

// Plain property, sampled on the rising edge, off during reset.
`define SBCR_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("sbcr check failed");

// Same-cycle implication.
`define SBCR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sbcr check failed");

// Next-cycle implication.
`define SBCR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sbcr check failed");

`endif

[hw/rtl/sbcr_pkg.sv]
package sbcr_pkg;

	localparam int GW       = 28;  // geometry sums
	localparam int VW       = 16;
	localparam int QW       = 17;  // Q0.16 time, 1.0 included
	localparam int DIVSTEPS = QW;  // one quotient bit per stage
	localparam logic [QW-1:0] T_ONE = 17'h10000;

	typedef logic signed [GW-1:0] geo_t;
	typedef logic signed [VW-1:0] vel_t;
	typedef logic signed [VW:0]   rel_t;
	typedef logic [VW-1:0]        mag_t;
	typedef logic [QW-1:0]        quo_t;

	typedef enum logic [2:0] {
		CODE_NONE    = 3'd0,
		CODE_TOUCH   = 3'd1,
		CODE_LEFT    = 3'd2,
		CODE_RIGHT   = 3'd3,
		CODE_GROUND  = 3'd4,
		CODE_CEILING = 3'd5
	} code_t;

	typedef struct packed {
		logic signed [23:0] first_pos_x;
		logic signed [23:0] first_pos_y;
		vel_t               first_vel_x;
		vel_t               first_vel_y;
		logic signed [23:0] second_pos_x;
		logic signed [23:0] second_pos_y;
		vel_t               second_vel_x;
		vel_t               second_vel_y;
		logic [31:0]        first_box_horiz;
		logic [31:0]        first_box_vert;
		logic [31:0]        second_box_horiz;
		logic [31:0]        second_box_vert;
	} in_word_t;

	typedef struct packed {
		logic [2:0] contact_code;
		vel_t       new_first_vel_x;
		vel_t       new_first_vel_y;
		vel_t       new_second_vel_x;
		vel_t       new_second_vel_y;
	} out_word_t;

	// Per-item context carried alongside the divider.
	typedef struct packed {
		vel_t v1x;
		vel_t v1y;
		vel_t v2x;
		vel_t v2y;
		logic ltx;
		logic gtx;
		logic lty;
		logic gty;
		logic okx;
		logic oky;
		logic hit;
		logic dx0;
		logic dy0;
	} ctx_t;

	typedef struct packed {
		logic [QW-1:0] rem;
		mag_t          den;
		quo_t          quo;
	} div_t;

	typedef struct packed {
		logic ok;
		logic hit;
		mag_t num;
		mag_t den;
	} ax_t;

	function automatic ax_t axis_prep(rel_t d, geo_t lo, geo_t hi, geo_t p);
		geo_t num;
		geo_t de;
		geo_t nn;
		rel_t dn;
		ax_t  r;
		de = geo_t'(d);
		num = ((d > 0) ? lo : hi) - p;
		nn = -num;
		dn = -d;
		if (d > 0)
			r.ok = (num >= 0) && (num <= de);
		else if (d < 0)
			r.ok = (num <= 0) && (num >= de);
		else
			r.ok = 1'b0;
		r.hit = r.ok || ((p >= lo) && (p <= hi));
		r.num = (num < 0) ? nn[VW-1:0] : num[VW-1:0];
		r.den = (d < 0) ? dn[VW-1:0] : d[VW-1:0];
		return r;
	endfunction

	// One restoring step; the first step compares without shifting.
	function automatic div_t div_step(div_t a, logic first);
		logic [QW-1:0] rt;
		div_t r;
		rt = first ? a.rem : {a.rem[QW-2:0], 1'b0};
		r.den = a.den;
		if (rt >= {1'b0, a.den}) begin
			r.rem = rt - {1'b0, a.den};
			r.quo = {a.quo[QW-2:0], 1'b1};
		end else begin
			r.rem = rt;
			r.quo = {a.quo[QW-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage

[hw/rtl/swept_box_collision_response.sv]
// Throughput: one word per cycle; every stage holds when the output is stalled.
// The depth is set by the restoring divider, one quotient bit per stage, 17 stages.
// Reset (arst_n low, asynchronous) clears all stage valid bits; payload is not reset.
// No state between words: each box pair is independent.
module swept_box_collision_response (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  sbcr_pkg::in_word_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output sbcr_pkg::out_word_t  out_data
);

`include "swept_box_collision_response_macros.svh"

	localparam int ND = sbcr_pkg::DIVSTEPS;

	// Whole pipe moves together; it only holds while the output word waits.
	logic adv;
	assign adv = !out_valid || out_ready;
	assign in_ready = adv;

	// ---------------- stage 1: geometry sums ----------------
	logic             vld_s1;
	sbcr_pkg::geo_t   ptx_s1, pty_s1, rl_s1, rt_s1, rr_s1, rb_s1;
	sbcr_pkg::rel_t   dx_s1, dy_s1;
	sbcr_pkg::ctx_t   ctx_s1;

	sbcr_pkg::geo_t   l1, r1, t1, b1, l2, r2, t2, b2;
	sbcr_pkg::geo_t   p1x, p1y, p2x, p2y;

	always_comb begin
		l1 = sbcr_pkg::geo_t'($signed(in_data.first_box_horiz[15:0]));
		r1 = sbcr_pkg::geo_t'($signed(in_data.first_box_horiz[31:16]));
		t1 = sbcr_pkg::geo_t'($signed(in_data.first_box_vert[15:0]));
		b1 = sbcr_pkg::geo_t'($signed(in_data.first_box_vert[31:16]));
		l2 = sbcr_pkg::geo_t'($signed(in_data.second_box_horiz[15:0]));
		r2 = sbcr_pkg::geo_t'($signed(in_data.second_box_horiz[31:16]));
		t2 = sbcr_pkg::geo_t'($signed(in_data.second_box_vert[15:0]));
		b2 = sbcr_pkg::geo_t'($signed(in_data.second_box_vert[31:16]));
		p1x = sbcr_pkg::geo_t'(in_data.first_pos_x);
		p1y = sbcr_pkg::geo_t'(in_data.first_pos_y);
		p2x = sbcr_pkg::geo_t'(in_data.second_pos_x);
		p2y = sbcr_pkg::geo_t'(in_data.second_pos_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// leading corner of the first box and the expanded target rectangle
			ptx_s1 <= p1x + l1;
			pty_s1 <= p1y + t1;
			rl_s1  <= p2x + l2 - (r1 - l1);
			rt_s1  <= p2y + t2 - (b1 - t1);
			rr_s1  <= p2x + r2;
			rb_s1  <= p2y + b2;
			dx_s1  <= sbcr_pkg::rel_t'(in_data.first_vel_x)
				- sbcr_pkg::rel_t'(in_data.second_vel_x);
			dy_s1  <= sbcr_pkg::rel_t'(in_data.first_vel_y)
				- sbcr_pkg::rel_t'(in_data.second_vel_y);
			ctx_s1.v1x <= in_data.first_vel_x;
			ctx_s1.v1y <= in_data.first_vel_y;
			ctx_s1.v2x <= in_data.second_vel_x;
			ctx_s1.v2y <= in_data.second_vel_y;
			ctx_s1.ltx <= in_data.first_pos_x < in_data.second_pos_x;
			ctx_s1.gtx <= in_data.first_pos_x > in_data.second_pos_x;
			ctx_s1.lty <= in_data.first_pos_y < in_data.second_pos_y;
			ctx_s1.gty <= in_data.first_pos_y > in_data.second_pos_y;
			ctx_s1.okx <= 1'b0;
			ctx_s1.oky <= 1'b0;
			ctx_s1.hit <= 1'b0;
			ctx_s1.dx0 <= 1'b0;
			ctx_s1.dy0 <= 1'b0;
		end
	end

	// ---------------- stage 2: entry numerators, range checks ----------------
	// Index 0 of the divider arrays is the stage 2 register; index k holds the
	// word after k quotient bits.
	logic             vld_sd [0:ND];
	sbcr_pkg::ctx_t   ctx_sd [0:ND];
	sbcr_pkg::div_t   dvx_sd [0:ND];
	sbcr_pkg::div_t   dvy_sd [0:ND];

	sbcr_pkg::ax_t    axx, axy;
	assign axx = sbcr_pkg::axis_prep(dx_s1, rl_s1, rr_s1, ptx_s1);
	assign axy = sbcr_pkg::axis_prep(dy_s1, rt_s1, rb_s1, pty_s1);

	sbcr_pkg::ctx_t   ctx_nx;

	always_comb begin
		ctx_nx     = ctx_s1;
		ctx_nx.okx = axx.ok;
		ctx_nx.oky = axy.ok;
		ctx_nx.hit = axx.hit && axy.hit;
		ctx_nx.dx0 = dx_s1 == '0;
		ctx_nx.dy0 = dy_s1 == '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sd[0] <= 1'b0;
		end else if (adv) begin
			vld_sd[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_sd[0] <= ctx_nx;
			dvx_sd[0] <= '{rem: {1'b0, axx.num}, den: axx.den, quo: '0};
			dvy_sd[0] <= '{rem: {1'b0, axy.num}, den: axy.den, quo: '0};
		end
	end

	// ---------------- stages 3..19: restoring divider, both axes ----------------
	// Where the entry time is in range the numerator does not exceed the divisor, so the quotient fits Q0.16 with 1.0.
	for (genvar k = 1; k <= ND; k++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sd[k] <= 1'b0;
			end else if (adv) begin
				vld_sd[k] <= vld_sd[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				ctx_sd[k] <= ctx_sd[k-1];
				dvx_sd[k] <= sbcr_pkg::div_step(dvx_sd[k-1], k == 1);
				dvy_sd[k] <= sbcr_pkg::div_step(dvy_sd[k-1], k == 1);
			end
		end
	end

	// ---------------- stage 20: axis choice, who gets scaled ----------------
	sbcr_pkg::ctx_t   cd;
	sbcr_pkg::quo_t   tx, ty;
	logic             selx, sely;
	sbcr_pkg::vel_t   a1, a2;
	logic             lt, gt, same, firstv;
	logic [sbcr_pkg::VW:0] a1n, a2n;

	assign cd = ctx_sd[ND];
	assign tx = dvx_sd[ND].quo;
	assign ty = dvy_sd[ND].quo;

	always_comb begin
		selx = cd.okx && (!cd.oky || (tx <= ty));   // x wins a tie
		sely = !selx && cd.oky;
		a1 = selx ? cd.v1x : cd.v1y;
		a2 = selx ? cd.v2x : cd.v2y;
		lt = selx ? cd.ltx : cd.lty;
		gt = selx ? cd.gtx : cd.gty;
		same = ((a1 > 0) && (a2 > 0)) || ((a1 < 0) && (a2 < 0));
		firstv = (a1 > 0) ? lt : gt;                // trailing box is the first
		a1n = -sbcr_pkg::rel_t'(a1);
		a2n = -sbcr_pkg::rel_t'(a2);
	end

	logic                   vld_s20;
	sbcr_pkg::ctx_t         ctx_s20;
	logic                   selx_s20, sely_s20, sc1_s20, sc2_s20;
	logic                   neg1_s20, neg2_s20;
	logic [sbcr_pkg::VW:0]  m1_s20, m2_s20;
	sbcr_pkg::quo_t         t_s20;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s20 <= 1'b0;
		end else if (adv) begin
			vld_s20 <= vld_sd[ND];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s20  <= cd;
			selx_s20 <= selx;
			sely_s20 <= sely;
			sc1_s20  <= !same || firstv;
			sc2_s20  <= !same || !firstv;
			neg1_s20 <= a1 < 0;
			neg2_s20 <= a2 < 0;
			m1_s20   <= (a1 < 0) ? a1n : {1'b0, a1};
			m2_s20   <= (a2 < 0) ? a2n : {1'b0, a2};
			t_s20    <= selx ? tx : ty;
		end
	end

	// ---------------- stage 21: velocity * time ----------------
	logic [2*sbcr_pkg::QW-1:0] pr1, pr2;
	assign pr1 = m1_s20 * t_s20;
	assign pr2 = m2_s20 * t_s20;

	logic                   vld_s21;
	sbcr_pkg::ctx_t         ctx_s21;
	logic                   selx_s21, sely_s21, sc1_s21, sc2_s21;
	logic                   neg1_s21, neg2_s21;
	logic [sbcr_pkg::VW:0]  q1_s21, q2_s21;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s21 <= 1'b0;
		end else if (adv) begin
			vld_s21 <= vld_s20;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s21  <= ctx_s20;
			selx_s21 <= selx_s20;
			sely_s21 <= sely_s20;
			sc1_s21  <= sc1_s20;
			sc2_s21  <= sc2_s20;
			neg1_s21 <= neg1_s20;
			neg2_s21 <= neg2_s20;
			q1_s21   <= pr1[32:16];    // truncated toward zero on the magnitude
			q2_s21   <= pr2[32:16];
		end
	end

	// ---------------- stage 22: response and output register ----------------
	sbcr_pkg::ctx_t        c;
	logic [sbcr_pkg::VW:0] q1n, q2n;
	sbcr_pkg::vel_t        s1v, s2v;
	sbcr_pkg::out_word_t   ow;
	logic                  fy, fx;

	always_comb begin
		c = ctx_s21;
		q1n = -q1_s21;
		q2n = -q2_s21;
		s1v = neg1_s21 ? q1n[sbcr_pkg::VW-1:0] : q1_s21[sbcr_pkg::VW-1:0];
		s2v = neg2_s21 ? q2n[sbcr_pkg::VW-1:0] : q2_s21[sbcr_pkg::VW-1:0];
		fy = (c.v1y > 0) ? c.lty : c.gty;
		fx = (c.v1x > 0) ? c.ltx : c.gtx;
		ow.contact_code     = sbcr_pkg::CODE_NONE;
		ow.new_first_vel_x  = c.v1x;
		ow.new_first_vel_y  = c.v1y;
		ow.new_second_vel_x = c.v2x;
		ow.new_second_vel_y = c.v2y;
		priority if (!c.hit) begin
			ow.contact_code = sbcr_pkg::CODE_NONE;
		end else if (selx_s21) begin
			ow.contact_code = c.ltx ? sbcr_pkg::CODE_RIGHT : sbcr_pkg::CODE_LEFT;
			if (sc1_s21) ow.new_first_vel_x = s1v;
			if (sc2_s21) ow.new_second_vel_x = s2v;
		end else if (sely_s21) begin
			ow.contact_code = c.lty ? sbcr_pkg::CODE_GROUND : sbcr_pkg::CODE_CEILING;
			if (sc1_s21) ow.new_first_vel_y = s1v;
			if (sc2_s21) ow.new_second_vel_y = s2v;
		end else begin
			// resting contact: no usable entry time on either axis
			ow.contact_code = sbcr_pkg::CODE_TOUCH;
			if (c.dy0) begin
				if (fy) ow.new_first_vel_y = '0;
				else    ow.new_second_vel_y = '0;
			end
			if (c.dx0) begin
				ow.contact_code = (c.v1x > 0) ? sbcr_pkg::CODE_RIGHT
					: sbcr_pkg::CODE_LEFT;
				if (fx) ow.new_first_vel_x = '0;
				else    ow.new_second_vel_x = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= vld_s21;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data <= ow;
		end
	end

	// ---------------- checks ----------------
	`SBCR_ASSERT_IMP(a_time_range, clk, arst_n, vld_sd[ND] && cd.okx, tx <= sbcr_pkg::T_ONE)
	`SBCR_ASSERT_IMP(a_one_axis, clk, arst_n, vld_sd[ND], !(selx && sely))
	`SBCR_ASSERT_NXT(a_hold_on_stall, clk, arst_n, !adv, $stable(vld_s21) && $stable(vld_s20))

endmodule
